[rtl/interval_union_coverage_defines.svh]
// Assertion helpers shared by the interval union coverage RTL.
`ifndef INTERVAL_UNION_COVERAGE_DEFINES_SVH
`define INTERVAL_UNION_COVERAGE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IUC_ASSERT_IMP(NAME, CLK, RSTN, ANTE, CONS, MSG) \
  NAME: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
    else $error(MSG);

// Next-cycle implication, disabled while reset is asserted.
`define IUC_ASSERT_NXT(NAME, CLK, RSTN, ANTE, CONS, MSG) \
  NAME: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) \
    else $error(MSG);

`endif

[rtl/iuc_pkg.sv]
`timescale 1ns / 1ps

package iuc_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_INTERVALS_DEF = 64;
  localparam int COORD_BITS_DEF    = 32;

  // Fixed field widths of the channels
  localparam int SEG_W   = 32;
  localparam int TOTAL_W = 33;

  typedef enum logic [0:0] {
    KIND_ADD   = 1'b0,
    KIND_QUERY = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [SEG_W-1:0] seg_start;
    logic [SEG_W-1:0] seg_end;
  } in_item_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] covered_total;
    logic               overflowed;
  } out_item_t;

  // Command broadcast from the controller to every cell
  typedef struct packed {
    logic cmp;  // latch overlap flags against the held interval
    logic ins;  // open a new entry, shift the tail up by one
    logic mrg;  // write the merged entry, retire absorbed entries
    logic shf;  // close up one retired entry, shift the tail down
  } iuc_cmd_t;

endpackage

[rtl/iuc_cell.sv]
`timescale 1ns / 1ps

module iuc_cell #(
  parameter int CB  = 32,
  parameter int CW  = 7,
  parameter int IDX = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  iuc_pkg::iuc_cmd_t cmd,
  input  logic [CB-1:0]    seg_s,
  input  logic [CB-1:0]    seg_e,
  input  logic [CB-1:0]    nw_start,
  input  logic [CB-1:0]    nw_end,
  input  logic [CB:0]      nw_psum,
  input  logic [CB:0]      delta,
  input  logic [CW-1:0]    count,
  input  logic [CB-1:0]    prev_start,
  input  logic [CB-1:0]    prev_end,
  input  logic [CB:0]      prev_psum,
  input  logic             prev_below,
  input  logic [CB-1:0]    next_start,
  input  logic [CB-1:0]    next_end,
  input  logic [CB:0]      next_psum,
  input  logic             next_below,
  input  logic             next_ov,
  input  logic             next_dead,
  output logic [CB-1:0]    cur_start,
  output logic [CB-1:0]    cur_end,
  output logic [CB:0]      cur_psum,
  output logic             below,
  output logic             ov,
  output logic             dead,
  output logic             lo,
  output logic [CB-1:0]    sel_start,
  output logic [CB-1:0]    sel_end,
  output logic [CB:0]      sel_base,
  output logic [CB:0]      sel_phi,
  output logic             more
);
  import iuc_pkg::*;

  // Entry payload; psum_r is the covered length of this entry and all before it
  logic [CB-1:0] start_r;
  logic [CB-1:0] end_r;
  logic [CB:0]   psum_r;
  logic          below_r;
  logic          ov_r;
  logic          dead_r;

  logic occ;
  logic hit_below;
  logic hit_ov;
  logic last_ov;
  logic last_below;

  // Compare the held interval against this entry
  assign occ       = count > CW'(IDX);
  assign hit_below = occ && (end_r < seg_s);
  assign hit_ov    = occ && !(end_r < seg_s) && (start_r <= seg_e);

  // Locate the insertion point and the edges of the overlapped run
  assign lo         = !below_r && prev_below;
  assign last_ov    = ov_r && !next_ov;
  assign last_below = below_r && !next_below;

  assign sel_start = (lo && ov_r) ? start_r : '0;
  assign sel_end   = last_ov ? end_r : '0;
  assign sel_phi   = last_ov ? psum_r : '0;
  assign sel_base  = last_below ? psum_r : '0;
  assign more      = lo && next_dead;

  assign cur_start = start_r;
  assign cur_end   = end_r;
  assign cur_psum  = psum_r;
  assign below     = below_r;
  assign ov        = ov_r;
  assign dead      = dead_r;

  // Hold flags; latch them on compare, mark absorbed entries on merge, pass marks down on close-up
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      below_r <= 1'b0;
      ov_r    <= 1'b0;
      dead_r  <= 1'b0;
    end else if (cmd.cmp) begin
      below_r <= hit_below;
      ov_r    <= hit_ov;
      dead_r  <= 1'b0;
    end else if (cmd.mrg) begin
      if (!below_r && !lo && ov_r) begin
        dead_r <= 1'b1;
      end
    end else if (cmd.shf) begin
      if (!below_r && !lo) begin
        dead_r <= next_dead;
      end
    end
  end

  // Move entry payload: insert shifts up, merge rewrites, shift closes gaps
  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      if (lo) begin
        start_r <= nw_start;
        end_r   <= nw_end;
        psum_r  <= nw_psum;
      end else if (!below_r) begin
        start_r <= prev_start;
        end_r   <= prev_end;
        psum_r  <= prev_psum + delta;
      end
    end else if (cmd.mrg) begin
      if (lo) begin
        start_r <= nw_start;
        end_r   <= nw_end;
        psum_r  <= nw_psum;
      end else if (!below_r && !ov_r) begin
        psum_r <= psum_r + delta;
      end
    end else if (cmd.shf) begin
      if (!below_r && !lo) begin
        start_r <= next_start;
        end_r   <= next_end;
        psum_r  <= next_psum;
      end
    end
  end

endmodule

[rtl/iuc_ctrl.sv]
`timescale 1ns / 1ps
`include "interval_union_coverage_defines.svh"

module iuc_ctrl #(
  parameter int MAXI = 64,
  parameter int CB   = 32,
  parameter int CW   = 7
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  iuc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output iuc_pkg::out_item_t out_data,
  input  logic               any_ov,
  input  logic               more,
  input  logic [CB-1:0]      sel_start,
  input  logic [CB-1:0]      sel_end,
  input  logic [CB:0]        sel_base,
  input  logic [CB:0]        sel_phi,
  output iuc_pkg::iuc_cmd_t  cmd,
  output logic [CB-1:0]      seg_s,
  output logic [CB-1:0]      seg_e,
  output logic [CB-1:0]      nw_start,
  output logic [CB-1:0]      nw_end,
  output logic [CB:0]        nw_psum,
  output logic [CB:0]        delta,
  output logic [CW-1:0]      count
);
  import iuc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_SEL,
    ST_CALC,
    ST_DLT,
    ST_UPD,
    ST_SHIFT
  } state_t;

  state_t         state_r;
  logic [CW-1:0]  count_r;
  logic [CB:0]    total_r;
  logic           ovf_r;
  logic           out_valid_r;
  out_item_t      out_data_r;
  logic [CB-1:0]  seg_s_r;
  logic [CB-1:0]  seg_e_r;
  logic           any_ov_r;
  logic [CB-1:0]  ns_r;
  logic [CB-1:0]  ne_r;
  logic [CB:0]    base_r;
  logic [CB:0]    phi_r;
  logic [CB:0]    len_r;
  logic [CB:0]    span_r;
  logic [CB:0]    delta_r;
  logic [CB:0]    npsum_r;

  logic                 accept;
  logic                 full;
  logic [CB+SEG_W-1:0]  s_wide;
  logic [CB+SEG_W-1:0]  e_wide;
  logic [CB+TOTAL_W:0]  tot_wide;

  // Reduce incoming coordinates to the coordinate width
  assign s_wide   = {{CB{1'b0}}, in_data.seg_start};
  assign e_wide   = {{CB{1'b0}}, in_data.seg_end};
  assign tot_wide = {{TOTAL_W{1'b0}}, total_r};

  assign full   = count_r == CW'(MAXI);
  assign accept = in_valid && !in_stall;

  // Stall while an add is in flight, or a query would find the result slot taken
  assign in_stall = (state_r != ST_IDLE) ||
                    ((in_data.kind == KIND_QUERY) && out_valid_r && out_stall);

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign seg_s     = seg_s_r;
  assign seg_e     = seg_e_r;
  assign nw_start  = ns_r;
  assign nw_end    = ne_r;
  assign nw_psum   = npsum_r;
  assign delta     = delta_r;
  assign count     = count_r;

  // Drive the cell chain from the current step
  always_comb begin
    cmd     = '0;
    cmd.cmp = state_r == ST_CMP;
    cmd.ins = (state_r == ST_UPD) && !any_ov_r && !full;
    cmd.mrg = (state_r == ST_UPD) && any_ov_r;
    cmd.shf = (state_r == ST_SHIFT) && more;
  end

  // Sequence one add through compare, select, length, delta, update and close-up; answer queries in idle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      total_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // raise the result on a query transfer, drop it once taken
      if (accept && (in_data.kind == KIND_QUERY)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            if (in_data.kind == KIND_QUERY) begin
              out_data_r.covered_total <= tot_wide[TOTAL_W-1:0];
              out_data_r.overflowed    <= ovf_r;
            end else begin
              seg_s_r <= s_wide[CB-1:0];
              seg_e_r <= e_wide[CB-1:0];
              state_r <= ST_CMP;
            end
          end
        end
        ST_CMP: begin
          // drop a reversed interval
          state_r <= (seg_s_r > seg_e_r) ? ST_IDLE : ST_SEL;
        end
        ST_SEL: begin
          any_ov_r <= any_ov;
          base_r   <= sel_base;
          if (any_ov) begin
            ns_r  <= (sel_start < seg_s_r) ? sel_start : seg_s_r;
            ne_r  <= (sel_end > seg_e_r) ? sel_end : seg_e_r;
            phi_r <= sel_phi;
          end else begin
            ns_r  <= seg_s_r;
            ne_r  <= seg_e_r;
            phi_r <= sel_base;
          end
          state_r <= ST_CALC;
        end
        ST_CALC: begin
          len_r   <= {1'b0, ne_r} - {1'b0, ns_r} + {{CB{1'b0}}, 1'b1};
          span_r  <= phi_r - base_r;
          state_r <= ST_DLT;
        end
        ST_DLT: begin
          delta_r <= len_r - span_r;
          npsum_r <= base_r + len_r;
          state_r <= ST_UPD;
        end
        ST_UPD: begin
          if (!any_ov_r && full) begin
            ovf_r   <= 1'b1;
            state_r <= ST_IDLE;
          end else begin
            total_r <= total_r + delta_r;
            if (any_ov_r) begin
              state_r <= ST_SHIFT;
            end else begin
              count_r <= count_r + CW'(1);
              state_r <= ST_IDLE;
            end
          end
        end
        ST_SHIFT: begin
          // close up one absorbed entry per cycle
          if (more) begin
            count_r <= count_r - CW'(1);
          end else begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  `IUC_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(MAXI), "entry count above table size")
  `IUC_ASSERT_NXT(a_ovf_sticky, clk, rst_n, ovf_r, ovf_r, "overflow flag cleared")
  `IUC_ASSERT_NXT(a_total_hold, clk, rst_n, state_r != ST_UPD, $stable(total_r), "total changed outside update")
  `IUC_ASSERT_NXT(a_shift_count, clk, rst_n, cmd.shf, count_r == $past(count_r) - CW'(1), "close-up did not retire an entry")

endmodule

[rtl/interval_union_coverage.sv]
`timescale 1ns / 1ps
`include "interval_union_coverage_defines.svh"

// Interval union coverage: keeps up to MAX_INTERVALS sorted, disjoint closed
// intervals in a chain of cells, each cell holding one entry and the running
// covered length up to it. An add merges the new interval with every entry it
// overlaps (intervals that only touch stay apart); a query returns the covered
// total and the sticky overflow flag, set when an add needing a new entry
// finds the table full. A query's result is registered, so queries flow back
// to back while the result side keeps up. An add holds the input through the
// compare, select, length, delta and update steps of the controller, and
// when it overlaps entries also while the chain closes up absorbed entries
// one per cycle; a reversed interval is dropped after the compare step. No
// clearing pass runs after reset.
module interval_union_coverage #(
  parameter int MAX_INTERVALS = iuc_pkg::MAX_INTERVALS_DEF,
  parameter int COORD_BITS    = iuc_pkg::COORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  iuc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output iuc_pkg::out_item_t out_data
);
  import iuc_pkg::*;

  localparam int N  = MAX_INTERVALS;
  localparam int CB = COORD_BITS;
  localparam int CW = $clog2(MAX_INTERVALS + 1);

  iuc_cmd_t      cmd;
  logic [CB-1:0] seg_s;
  logic [CB-1:0] seg_e;
  logic [CB-1:0] nw_start;
  logic [CB-1:0] nw_end;
  logic [CB:0]   nw_psum;
  logic [CB:0]   delta;
  logic [CW-1:0] count;

  logic [CB-1:0] c_start [N];
  logic [CB-1:0] c_end   [N];
  logic [CB:0]   c_psum  [N];
  logic [CB-1:0] c_sel_start [N];
  logic [CB-1:0] c_sel_end   [N];
  logic [CB:0]   c_sel_base  [N];
  logic [CB:0]   c_sel_phi   [N];
  logic [N-1:0]  below_vec;
  logic [N-1:0]  ov_vec;
  logic [N-1:0]  dead_vec;
  logic [N-1:0]  lo_vec;
  logic [N-1:0]  more_vec;

  logic          any_ov;
  logic          more;
  logic [CB-1:0] sel_start;
  logic [CB-1:0] sel_end;
  logic [CB:0]   sel_base;
  logic [CB:0]   sel_phi;

  // Build the chain, tying off the neighbours beyond either end
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [CB-1:0] p_start;
    logic [CB-1:0] p_end;
    logic [CB:0]   p_psum;
    logic          p_below;
    logic [CB-1:0] n_start;
    logic [CB-1:0] n_end;
    logic [CB:0]   n_psum;
    logic          n_below;
    logic          n_ov;
    logic          n_dead;

    if (i == 0) begin : g_head
      assign p_start = '0;
      assign p_end   = '0;
      assign p_psum  = '0;
      assign p_below = 1'b1;
    end else begin : g_link_prev
      assign p_start = c_start[i-1];
      assign p_end   = c_end[i-1];
      assign p_psum  = c_psum[i-1];
      assign p_below = below_vec[i-1];
    end

    if (i == N - 1) begin : g_tail
      assign n_start = '0;
      assign n_end   = '0;
      assign n_psum  = '0;
      assign n_below = 1'b0;
      assign n_ov    = 1'b0;
      assign n_dead  = 1'b0;
    end else begin : g_link_next
      assign n_start = c_start[i+1];
      assign n_end   = c_end[i+1];
      assign n_psum  = c_psum[i+1];
      assign n_below = below_vec[i+1];
      assign n_ov    = ov_vec[i+1];
      assign n_dead  = dead_vec[i+1];
    end

    iuc_cell #(
      .CB  (CB),
      .CW  (CW),
      .IDX (i)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .seg_s      (seg_s),
      .seg_e      (seg_e),
      .nw_start   (nw_start),
      .nw_end     (nw_end),
      .nw_psum    (nw_psum),
      .delta      (delta),
      .count      (count),
      .prev_start (p_start),
      .prev_end   (p_end),
      .prev_psum  (p_psum),
      .prev_below (p_below),
      .next_start (n_start),
      .next_end   (n_end),
      .next_psum  (n_psum),
      .next_below (n_below),
      .next_ov    (n_ov),
      .next_dead  (n_dead),
      .cur_start  (c_start[i]),
      .cur_end    (c_end[i]),
      .cur_psum   (c_psum[i]),
      .below      (below_vec[i]),
      .ov         (ov_vec[i]),
      .dead       (dead_vec[i]),
      .lo         (lo_vec[i]),
      .sel_start  (c_sel_start[i]),
      .sel_end    (c_sel_end[i]),
      .sel_base   (c_sel_base[i]),
      .sel_phi    (c_sel_phi[i]),
      .more       (more_vec[i])
    );
  end

  // Gather the one-hot selections from the chain
  assign any_ov = |ov_vec;
  assign more   = |more_vec;

  always_comb begin
    sel_start = '0;
    sel_end   = '0;
    sel_base  = '0;
    sel_phi   = '0;
    for (int k = 0; k < N; k++) begin
      sel_start = sel_start | c_sel_start[k];
      sel_end   = sel_end | c_sel_end[k];
      sel_base  = sel_base | c_sel_base[k];
      sel_phi   = sel_phi | c_sel_phi[k];
    end
  end

  iuc_ctrl #(
    .MAXI (N),
    .CB   (CB),
    .CW   (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .any_ov    (any_ov),
    .more      (more),
    .sel_start (sel_start),
    .sel_end   (sel_end),
    .sel_base  (sel_base),
    .sel_phi   (sel_phi),
    .cmd       (cmd),
    .seg_s     (seg_s),
    .seg_e     (seg_e),
    .nw_start  (nw_start),
    .nw_end    (nw_end),
    .nw_psum   (nw_psum),
    .delta     (delta),
    .count     (count)
  );

  `IUC_ASSERT_IMP(a_lo_onehot, clk, rst_n, 1'b1, $onehot0(lo_vec), "more than one insertion point")

endmodule
